>>> rtl/xbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package xbc_pkg;

	localparam logic [31:0] DELTA       = 32'h9e37_79b9;
	localparam int          CFG_W       = 6;
	localparam logic [5:0]  ROUND_RESET = 6'd6;
	localparam int          QDEPTH      = 2;

	typedef struct packed {
		logic [31:0] data_word;
		logic        last_word;
		logic        decrypt;
		logic [31:0] key_word_0;
		logic [31:0] key_word_1;
		logic [31:0] key_word_2;
		logic [31:0] key_word_3;
	} in_item_t;

	typedef struct packed {
		logic [31:0] result_word;
		logic        last_result;
		logic        overflowed;
	} out_item_t;

	// one classified request, front to back
	typedef struct packed {
		logic [31:0]      word;
		logic [3:0][31:0] key;
		logic             decrypt;
		logic             first;
		logic             last;
		logic             store;
		logic             ovf;
	} job_t;

endpackage
`default_nettype wire

>>> rtl/xbc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module xbc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/xbc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module xbc_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire xbc_pkg::job_t push_job,
	output logic               full,
	input  wire logic          pop,
	output xbc_pkg::job_t      pop_job,
	output logic               nonempty
);
	import xbc_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	job_t          ent_q [QDEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (cnt_q == (PW+1)'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign pop_job  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : PW'(wp_q + 1'b1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : PW'(rp_q + 1'b1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= (PW+1)'(cnt_q + 1'b1);
				2'b01:   cnt_q <= (PW+1)'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= push_job;
		end
	end

endmodule
`default_nettype wire

>>> rtl/xbc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module xbc_front #(
	parameter int MAX_WORDS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire xbc_pkg::in_item_t in_data,
	output logic                   q_push,
	output xbc_pkg::job_t          q_job,
	input  wire logic              q_full
);
	import xbc_pkg::*;

	localparam int CW = $clog2(MAX_WORDS + 1);

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          fits;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;
	assign fits     = (cnt_q < CW'(MAX_WORDS));

	always_comb begin
		q_job.word    = in_data.data_word;
		q_job.key[0]  = in_data.key_word_0;
		q_job.key[1]  = in_data.key_word_1;
		q_job.key[2]  = in_data.key_word_2;
		q_job.key[3]  = in_data.key_word_3;
		q_job.decrypt = in_data.decrypt;
		q_job.first   = (cnt_q == '0) && !ovf_q;
		q_job.last    = in_data.last_word;
		q_job.store   = fits;
		q_job.ovf     = ovf_q || !fits;
	end

	// word count and overflow of the block being received
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (q_push) begin
			if (in_data.last_word) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (fits) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/xbc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module xbc_back #(
	parameter int MAX_WORDS = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_valid,
	output logic                            q_pop,
	input  wire xbc_pkg::job_t              q_job,
	input  wire logic [xbc_pkg::CFG_W-1:0]  rounds,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output xbc_pkg::out_item_t              out_data
);
	import xbc_pkg::*;

	localparam int CW = $clog2(MAX_WORDS + 1);
	localparam int AW = $clog2(MAX_WORDS);

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_PRO1  = 3'd2;
	localparam logic [2:0] S_PRO2  = 3'd3;
	localparam logic [2:0] S_MIXA  = 3'd4;
	localparam logic [2:0] S_MIXB  = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;
	localparam logic [2:0] S_EWAIT = 3'd7;

	logic [2:0]       state_q;
	logic [CW-1:0]    wcnt_q;
	logic [CW-1:0]    n_q;
	logic             ovf_q;
	logic             dec_q;
	logic [3:0][31:0] key_q;
	logic [AW-1:0]    p_q;
	logic [AW-1:0]    ei_q;
	logic [CFG_W-1:0] rnd_q;
	logic [31:0]      sum_q;
	logic [31:0]      c_q;     // carried new value (z on encrypt, y on decrypt)
	logic [31:0]      nx_q;    // old value of the next target word
	logic [31:0]      rdh_q;
	logic [31:0]      a_q;
	logic [31:0]      b_q;
	logic             fwd_q;
	logic             ov_q;
	out_item_t        out_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [31:0]      ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [31:0]      ram_rdata;

	logic [AW-1:0]    nm1;
	logic [31:0]      rd_eff;
	logic [31:0]      y;
	logic [31:0]      z;
	logic [1:0]       kidx;
	logic [31:0]      mixv;
	logic [31:0]      newv;
	logic             rend;
	logic [AW-1:0]    p_next;
	logic             slot_free;
	logic             emit_last;

	function automatic logic [AW-1:0] step_addr(input logic [AW-1:0] p, input logic dec,
	                                            input logic [AW-1:0] last_idx);
		logic [AW-1:0] r;
		if (!dec) begin
			r = (p == last_idx) ? '0 : AW'(p + 1'b1);
		end else begin
			r = (p == '0) ? last_idx : AW'(p - 1'b1);
		end
		return r;
	endfunction

	xbc_ram #(
		.WIDTH (32),
		.DEPTH (MAX_WORDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign nm1       = AW'(n_q - 1'b1);
	assign q_pop     = (state_q == S_LOAD) && q_valid;
	assign rd_eff    = fwd_q ? c_q : ram_rdata;
	assign y         = dec_q ? c_q : rd_eff;
	assign z         = dec_q ? rd_eff : c_q;
	assign kidx      = 2'(p_q) ^ sum_q[3:2];
	assign mixv      = a_q ^ b_q;
	assign newv      = dec_q ? (nx_q - mixv) : (nx_q + mixv);
	assign rend      = dec_q ? (p_q == '0) : (p_q == nm1);
	assign p_next    = rend ? (dec_q ? nm1 : '0) : step_addr(p_q, dec_q, nm1);
	assign slot_free = !ov_q || !out_stall;
	assign emit_last = (ei_q == nm1);
	assign out_valid = ov_q;
	assign out_data  = out_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = p_q;
		ram_wdata = newv;
		if (q_pop && q_job.store) begin
			ram_we    = 1'b1;
			ram_waddr = wcnt_q[AW-1:0];
			ram_wdata = q_job.word;
		end else if (state_q == S_MIXB) begin
			ram_we = 1'b1;
		end
	end

	always_comb begin
		unique case (state_q)
			S_START:         ram_raddr = dec_q ? '0 : nm1;
			S_PRO1:          ram_raddr = dec_q ? nm1 : '0;
			S_PRO2:          ram_raddr = step_addr(p_q, dec_q, nm1);
			S_MIXB:          ram_raddr = step_addr(p_next, dec_q, nm1);
			S_EMIT, S_EWAIT: ram_raddr = ei_q;
			default:         ram_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			wcnt_q  <= '0;
			ov_q    <= 1'b0;
			dec_q   <= 1'b0;
			ovf_q   <= 1'b0;
			n_q     <= '0;
			p_q     <= '0;
			ei_q    <= '0;
			rnd_q   <= '0;
			fwd_q   <= 1'b0;
		end else begin
			// output slot: load a word, or drop the one taken
			if ((state_q == S_EWAIT) && slot_free) begin
				ov_q <= 1'b1;
			end else if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (q_pop) begin
						if (q_job.first) begin
							dec_q <= q_job.decrypt;
						end
						if (q_job.store) begin
							wcnt_q <= CW'(wcnt_q + 1'b1);
						end
						if (q_job.last) begin
							n_q     <= q_job.store ? CW'(wcnt_q + 1'b1) : wcnt_q;
							ovf_q   <= q_job.ovf;
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					ei_q  <= '0;
					rnd_q <= '0;
					p_q   <= dec_q ? nm1 : '0;
					if (n_q < CW'(2) || rounds == '0) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_PRO1;
					end
				end
				S_PRO1: state_q <= S_PRO2;
				S_PRO2: begin
					fwd_q   <= 1'b0;
					state_q <= S_MIXA;
				end
				S_MIXA: state_q <= S_MIXB;
				S_MIXB: begin
					p_q   <= p_next;
					fwd_q <= (step_addr(p_next, dec_q, nm1) == p_q);
					if (rend) begin
						rnd_q <= CFG_W'(rnd_q + 1'b1);
						if (CFG_W'(rnd_q + 1'b1) == rounds) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_MIXA;
						end
					end else begin
						state_q <= S_MIXA;
					end
				end
				S_EMIT: state_q <= S_EWAIT;
				S_EWAIT: begin
					if (slot_free) begin
						if (emit_last) begin
							wcnt_q  <= '0;
							state_q <= S_LOAD;
						end else begin
							ei_q    <= AW'(ei_q + 1'b1);
							state_q <= S_EMIT;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop && q_job.first) begin
			key_q <= q_job.key;
		end
		unique case (state_q)
			S_START: sum_q <= dec_q ? 32'({26'd0, rounds} * DELTA) : DELTA;
			S_PRO1:  c_q   <= ram_rdata;
			S_PRO2:  nx_q  <= ram_rdata;
			S_MIXA: begin
				rdh_q <= rd_eff;
				a_q   <= ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
				b_q   <= (sum_q ^ y) + (key_q[kidx] ^ z);
			end
			S_MIXB: begin
				c_q  <= newv;
				nx_q <= rdh_q;
				if (rend) begin
					sum_q <= dec_q ? (sum_q - DELTA) : (sum_q + DELTA);
				end
			end
			S_EWAIT: begin
				if (slot_free) begin
					out_q.result_word <= ram_rdata;
					out_q.last_result <= emit_last;
					out_q.overflowed  <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/xxtea_block_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// XXTEA block cipher, one 32-bit word per request.
//
// Input channel (in_valid / in_stall / in_data): words of a block in order.
// The first word of a block also samples the 128-bit key and the direction;
// the word with last_word set closes the block. Words past MAX_WORDS are
// dropped and every result of that block carries overflowed.
// Output channel (out_valid / out_stall / out_data): one request per stored
// word, in original order, last_result on the final one.
// Config: cfg_we writes cfg_data into round_count (reset 6); write it idle.
//
// A front stage classifies words into a two-entry queue; the back stage
// stores them, then runs rounds * n mixing steps through one shared mix
// unit and a one-write one-read word store, then emits the words; it
// takes no word of the next block until the last result is emitted.
// Blocks of one word, or round_count of 0, pass through unchanged.
// Reset clears all control state and empties the queue and output.
// A stalled output holds its request; the back waits and the queue fills.
module xxtea_block_cipher #(
	parameter int MAX_WORDS = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire xbc_pkg::in_item_t         in_data,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output xbc_pkg::out_item_t             out_data,
	input  wire logic                      cfg_we,
	input  wire logic [xbc_pkg::CFG_W-1:0] cfg_data
);
	import xbc_pkg::*;

	logic [CFG_W-1:0] rounds_q;
	logic             q_push;
	job_t             push_job;
	logic             q_full;
	logic             q_pop;
	job_t             pop_job;
	logic             q_nonempty;

	// round_count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rounds_q <= ROUND_RESET;
		end else if (cfg_we) begin
			rounds_q <= cfg_data;
		end
	end

	xbc_front #(
		.MAX_WORDS (MAX_WORDS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_push   (q_push),
		.q_job    (push_job),
		.q_full   (q_full)
	);

	xbc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.nonempty (q_nonempty)
	);

	xbc_back #(
		.MAX_WORDS (MAX_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_nonempty),
		.q_pop     (q_pop),
		.q_job     (pop_job),
		.rounds    (rounds_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
